FILE: src/piecewise_linear_curve_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear curve block
// Clocked, reset-qualified implication checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CURVE_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PLC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plc assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plc assertion failed");

`endif

FILE: src/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants of the piecewise linear curve block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plc_pkg;

  localparam int DataW      = 16;            // Q8.8 sample and level width
  localparam int PointsDef  = 4;             // default breakpoint count
  localparam int PointsMax  = 4;             // register map holds four of each
  localparam int CfgIdxW    = 3;             // eight registers
  localparam int DivSteps   = DataW;         // one quotient bit per cell
  localparam int ResetStep  = 256;           // reset breakpoints/levels: j * 1.0

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BREAK_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_0 = 3'd4;

  typedef logic signed [DataW-1:0] q88_t;

  // segment select result
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] span;      // sample - left breakpoint
    logic [DataW-1:0] mag;       // |level difference|
    logic [DataW-1:0] divisor;   // breakpoint difference, 1 for flat output
    logic             neg;       // level difference is negative
    q88_t             base;      // left level
  } sel_beat_t;

  // beat moving along the divider chain
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] rem;       // partial remainder, always below divisor
    logic [DataW-1:0] low;       // dividend bits not yet consumed, MSB first
    logic [DataW-1:0] quo;       // quotient bits produced so far
    logic [DataW-1:0] divisor;
    logic             neg;
    q88_t             base;
  } div_beat_t;

endpackage

FILE: src/plc_select.sv
// ----------------------------------------------------------------------------
// plc_select
// Finds the enclosing segment and forms span, slope terms and base level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plc_select #(
  parameter int POINTS = plc_pkg::PointsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  plc_pkg::q88_t       sample_i,
  input  plc_pkg::q88_t       brk_i [POINTS],
  input  plc_pkg::q88_t       lvl_i [POINTS],
  output plc_pkg::sel_beat_t  sel_o
);

  localparam int W = plc_pkg::DataW;

  plc_pkg::sel_beat_t sel_d, sel_q;
  plc_pkg::q88_t      bl, br, ll, lr;
  logic               below, hit;
  logic signed [W:0]  dx, dy, dy_neg, sx;

  always_comb begin
    hit = 1'b0;
    bl  = brk_i[0];
    br  = brk_i[0];
    ll  = lvl_i[0];
    lr  = lvl_i[0];
    // walk down so the lowest matching segment wins
    for (int j = POINTS - 1; j >= 1; j--) begin
      if (sample_i >= brk_i[j-1] && sample_i <= brk_i[j]) begin
        hit = 1'b1;
        bl  = brk_i[j-1];
        br  = brk_i[j];
        ll  = lvl_i[j-1];
        lr  = lvl_i[j];
      end
    end
    below  = (sample_i <= brk_i[0]);
    dx     = {br[W-1], br} - {bl[W-1], bl};
    sx     = {sample_i[W-1], sample_i} - {bl[W-1], bl};
    dy     = {lr[W-1], lr} - {ll[W-1], ll};
    dy_neg = -dy;

    // flat output: zero span over a divisor of one
    sel_d.valid   = valid_i;
    sel_d.span    = '0;
    sel_d.mag     = '0;
    sel_d.divisor = W'(1);
    sel_d.neg     = 1'b0;
    sel_d.base    = lvl_i[POINTS-1];
    if (below) begin
      sel_d.base = lvl_i[0];
    end else if (hit) begin
      sel_d.base = ll;
      if (dx != '0) begin
        sel_d.span    = sx[W-1:0];
        sel_d.divisor = dx[W-1:0];
        sel_d.neg     = dy[W];
        sel_d.mag     = dy[W] ? dy_neg[W-1:0] : dy[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else begin
      sel_q <= sel_d;
    end
  end

  assign sel_o = sel_q;

endmodule

FILE: src/plc_div_cell.sv
// ----------------------------------------------------------------------------
// plc_div_cell
// One restoring division step: brings down a dividend bit, emits a quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plc_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plc_pkg::div_beat_t  beat_i,
  output plc_pkg::div_beat_t  beat_o
);

  localparam int W = plc_pkg::DataW;

  plc_pkg::div_beat_t beat_d, beat_q;
  logic [W:0]         trial, diff;
  logic               fits;

  always_comb begin
    trial  = {beat_i.rem, beat_i.low[W-1]};
    diff   = trial - {1'b0, beat_i.divisor};
    fits   = (trial >= {1'b0, beat_i.divisor});
    beat_d = beat_i;
    beat_d.rem = fits ? diff[W-1:0] : trial[W-1:0];
    beat_d.low = {beat_i.low[W-2:0], 1'b0};
    beat_d.quo = {beat_i.quo[W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

FILE: src/piecewise_linear_curve.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve
// Maps a signed Q8.8 sample through a configurable breakpoint curve.
// ----------------------------------------------------------------------------
// Usage: pulse start_i with sample_in_i; a new sample may be issued on every
// clock, busy_o never goes high. Each sample yields exactly one beat on
// curve_out_o, marked by a one-cycle done_o strobe, in issue order. The
// receiver cannot stall: capture curve_out_o whenever done_o is high.
// Throughput is one sample per cycle. The divider is a chain of 16 cells
// that each resolve one quotient bit. Pipeline: segment select, 16x16
// multiply, 16 divider cells, final add. Breakpoints and levels are written
// through cfg_we_i / cfg_idx_i / cfg_data_i (index 0..3 breakpoints, 4..7
// levels); write them only while no sample is in flight. Entries at or
// beyond POINTS in either bank are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_curve_macros.svh"

module piecewise_linear_curve #(
  parameter int POINTS = plc_pkg::PointsDef   // 2..4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample command
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [plc_pkg::DataW-1:0] sample_in_i,
  // result
  output logic                         done_o,
  output logic signed [plc_pkg::DataW-1:0] curve_out_o,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [plc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plc_pkg::DataW-1:0]    cfg_data_i
);

  localparam int W       = plc_pkg::DataW;
  localparam int Steps   = plc_pkg::DivSteps;
  localparam int Latency = Steps + 3;

  // --------------------------------------------------------------------------
  // Configuration registers: only the breakpoints and levels in use are kept.
  // --------------------------------------------------------------------------
  plc_pkg::q88_t brk_q [POINTS];
  plc_pkg::q88_t lvl_q [POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < POINTS; j++) begin
        brk_q[j] <= plc_pkg::q88_t'(j * plc_pkg::ResetStep);
        lvl_q[j] <= plc_pkg::q88_t'(j * plc_pkg::ResetStep);
      end
    end else if (cfg_we_i) begin
      for (int j = 0; j < POINTS; j++) begin
        if (cfg_idx_i == plc_pkg::REG_BREAK_0 + plc_pkg::CfgIdxW'(j)) begin
          brk_q[j] <= cfg_data_i;
        end
        if (cfg_idx_i == plc_pkg::REG_LEVEL_0 + plc_pkg::CfgIdxW'(j)) begin
          lvl_q[j] <= cfg_data_i;
        end
      end
    end
  end

  // fully pipelined, so a new sample is always taken
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // --------------------------------------------------------------------------
  // Stage 1: segment select
  // --------------------------------------------------------------------------
  plc_pkg::sel_beat_t sel;

  plc_select #(
    .POINTS (POINTS)
  ) u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .sample_i (sample_in_i),
    .brk_i    (brk_q),
    .lvl_i    (lvl_q),
    .sel_o    (sel)
  );

  // --------------------------------------------------------------------------
  // Stage 2: span * |dy|. The product is below divisor << W since span never
  // exceeds the divisor, so its upper half is a valid starting remainder.
  // --------------------------------------------------------------------------
  plc_pkg::div_beat_t chain [Steps+1];
  plc_pkg::div_beat_t mul_q;
  logic [2*W-1:0]     prod;

  assign prod = sel.span * sel.mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else begin
      mul_q.valid   <= sel.valid;
      mul_q.rem     <= prod[2*W-1:W];
      mul_q.low     <= prod[W-1:0];
      mul_q.quo     <= '0;
      mul_q.divisor <= sel.divisor;
      mul_q.neg     <= sel.neg;
      mul_q.base    <= sel.base;
    end
  end

  assign chain[0] = mul_q;

  // --------------------------------------------------------------------------
  // Divider: a row of cells, one quotient bit each, MSB first.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < Steps; i++) begin : g_div
    plc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Final stage: apply sign (truncation toward zero) and add the left level.
  // The sum lies between two levels, so 16 bits suffice.
  // --------------------------------------------------------------------------
  plc_pkg::div_beat_t fin;
  logic [W:0]         inc;
  logic               done_q;
  plc_pkg::q88_t      curve_q, curve_d;

  assign fin     = chain[Steps];
  assign inc     = fin.neg ? -{1'b0, fin.quo} : {1'b0, fin.quo};
  assign curve_d = fin.base + inc[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    curve_q <= curve_d;
  end

  assign done_o      = done_q;
  assign curve_out_o = curve_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // every result beat traces back to an earlier accepted sample
  `PLC_ASSERT_IMP(a_done_has_start, done_o, $past(accept, Latency))
  // multiplier output is a legal starting remainder
  `PLC_ASSERT_IMP(a_div_entry_rem, chain[0].valid, chain[0].rem < chain[0].divisor)
  // remainder stays in range through the whole chain
  `PLC_ASSERT_IMP(a_div_exit_rem, fin.valid, fin.rem < fin.divisor)
  // divider never sees a zero divisor
  `PLC_ASSERT_NEXT(a_sel_divisor, sel.valid, mul_q.divisor != '0)

endmodule

FILE: bench/curve_checker.sv
// ----------------------------------------------------------------------------
// curve_checker
// Watches the sample, result and register write ports of the curve block.
// It keeps its own copy of the breakpoint table and computes the expected
// level for every accepted sample. Each result beat is compared in order
// against those levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module curve_checker #(
  parameter int POINTS = plc_pkg::PointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  plc_pkg::q88_t                 sample_i,
  input  logic                          done_i,
  input  plc_pkg::q88_t                 curve_i,
  input  logic                          cfg_we_i,
  input  logic [plc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [plc_pkg::DataW-1:0]     cfg_data_i,
  output int                            errors_o,
  output int                            backlog_o,
  output int                            checked_o
);

  plc_pkg::q88_t brk [plc_pkg::PointsMax];
  plc_pkg::q88_t lvl [plc_pkg::PointsMax];
  plc_pkg::q88_t expected_levels [$];
  plc_pkg::q88_t want;
  int            mismatches;
  int            checked;
  int            backlog;

  assign errors_o  = mismatches;
  assign backlog_o = backlog;
  assign checked_o = checked;

  // first enclosing segment wins; exact product, quotient truncated toward zero
  function automatic plc_pkg::q88_t interpolate_level(input plc_pkg::q88_t s);
    longint bl, br, ll, lr, dx;
    if (s <= brk[0]) return lvl[0];
    for (int j = 1; j < POINTS; j++) begin
      bl = brk[j-1];
      br = brk[j];
      if (s >= bl && s <= br) begin
        ll = lvl[j-1];
        lr = lvl[j];
        dx = br - bl;
        if (dx == 0) return lvl[j-1];
        return plc_pkg::q88_t'(ll + (longint'(s) - bl) * (lr - ll) / dx);
      end
    end
    return lvl[POINTS-1];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < plc_pkg::PointsMax; k++) begin
        brk[k] = plc_pkg::q88_t'(k * plc_pkg::ResetStep);
        lvl[k] = plc_pkg::q88_t'(k * plc_pkg::ResetStep);
      end
      expected_levels.delete();
      mismatches = 0;
      checked    = 0;
      backlog    = 0;
    end else begin
      if ($isunknown(done_i)) begin
        $error("done_o: expected 0 or 1, got %b", done_i);
        mismatches++;
      end else if (done_i) begin
        if (expected_levels.size() == 0) begin
          $error("curve_out: expected no beat, got %0d", curve_i);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          checked++;
          if (curve_i !== want) begin
            $error("curve_out: expected %0d, got %0d", want, curve_i);
            mismatches++;
          end
        end
      end
      // a sample taken on a write edge still sees the old table
      if (start_i && !busy_i)
        expected_levels.push_back(interpolate_level(sample_i));
      if (cfg_we_i) begin
        if (cfg_idx_i < plc_pkg::REG_LEVEL_0)
          brk[cfg_idx_i - plc_pkg::REG_BREAK_0] = plc_pkg::q88_t'(cfg_data_i);
        else
          lvl[cfg_idx_i - plc_pkg::REG_LEVEL_0] = plc_pkg::q88_t'(cfg_data_i);
      end
      backlog = expected_levels.size();
    end
  end

endmodule

FILE: bench/piecewise_linear_curve_test.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_test
// Stimulus and verdict for the piecewise linear curve block. A short directed
// run at the reset curve comes first. It is followed by random samples under
// a series of breakpoint tables: full-scale, zero-width, unordered, flat and
// random ones. Samples go out in bursts with random gaps. curve_checker does
// all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_curve_test;

  // derived from the divider step count, used for the final wait
  localparam int LatencyCycles = plc_pkg::DivSteps + 3;
  localparam int RandomCurves  = 10;
  localparam int BeatsPerCurve = 125;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  plc_pkg::q88_t               sample_in_i;
  logic                        done_o;
  plc_pkg::q88_t               curve_out_o;
  logic                        cfg_we_i;
  logic [plc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [plc_pkg::DataW-1:0]   cfg_data_i;

  int   mismatches;
  int   backlog;
  int   checked;
  int   fed;
  int   burst_left;
  int   curves_run;
  // breakpoints last written, used to aim samples at segment edges
  plc_pkg::q88_t curve_breaks [plc_pkg::PointsMax];

  piecewise_linear_curve #(.POINTS(plc_pkg::PointsDef)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .sample_in_i (sample_in_i),
    .done_o      (done_o),
    .curve_out_o (curve_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  curve_checker #(.POINTS(plc_pkg::PointsDef)) curve_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .sample_i   (sample_in_i),
    .done_i     (done_o),
    .curve_i    (curve_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .errors_o   (mismatches),
    .backlog_o  (backlog),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Present one sample at the current falling edge and hold it until the
  // block takes it. Returns on a falling edge. When a burst runs out, start
  // drops for a random gap. Otherwise it stays high straight into the next beat.
  task automatic feed(input plc_pkg::q88_t s);
    start_i     <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    fed++;
    burst_left--;
    if (burst_left <= 0) begin
      start_i <= 1'b0;
      // mostly short gaps, now and then a long one
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(9, 40)) @(negedge clk_i);
      else
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      // some long bursts give stretches with no idle cycles at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Hold off until every issued sample has come back, then let the
  // pipeline go quiet.
  task automatic settle();
    start_i <= 1'b0;
    while (backlog != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all eight registers back to back. The block must be idle.
  task automatic load_curve(input int setting);
    plc_pkg::q88_t bk [plc_pkg::PointsMax];
    plc_pkg::q88_t lv [plc_pkg::PointsMax];
    int   vals [$];
    int   mode;
    int   base;
    for (int k = 0; k < plc_pkg::PointsMax; k++) lv[k] = plc_pkg::q88_t'($urandom);
    case (setting)
      0: begin
        // full-scale spans with full-scale level swings: largest products
        bk = '{16'sh8000, 16'shffff, 16'sh0000, 16'sh7fff};
        lv = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
      end
      1: bk = '{16'shfe00, 16'sh0100, 16'sh0100, 16'sh0400};  // zero-width middle
      2: bk = '{16'sh03e8, 16'shfe0c, 16'sh07d0, 16'sh05dc};  // out of order
      3: begin
        // every breakpoint on one value: flat curve on both sides
        bk[0] = plc_pkg::q88_t'($urandom);
        for (int k = 1; k < plc_pkg::PointsMax; k++) bk[k] = bk[0];
      end
      4: begin
        // zero-width segments at both ends of the range
        bk = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
        lv = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
      end
      default: begin
        mode = $urandom_range(0, 3);
        base = int'(plc_pkg::q88_t'($urandom));
        for (int k = 0; k < plc_pkg::PointsMax; k++) begin
          if (mode == 2) begin
            // tightly packed, often duplicate breakpoints
            base += $urandom_range(0, 64);
            vals.push_back(int'(plc_pkg::q88_t'(base)));
          end else begin
            vals.push_back(int'(plc_pkg::q88_t'($urandom)));
          end
        end
        if (mode != 0) vals.sort();
        for (int k = 0; k < plc_pkg::PointsMax; k++) bk[k] = plc_pkg::q88_t'(vals[k]);
      end
    endcase
    for (int k = 0; k < plc_pkg::PointsMax; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= plc_pkg::REG_BREAK_0 + 3'(k);
      cfg_data_i <= bk[k];
      @(negedge clk_i);
      cfg_idx_i  <= plc_pkg::REG_LEVEL_0 + 3'(k);
      cfg_data_i <= lv[k];
      @(negedge clk_i);
    end
    cfg_we_i     <= 1'b0;
    curve_breaks = bk;
  endtask

  // Sample mix: uniform over the full range, around breakpoints, at the
  // range limits, and inside a chosen segment.
  function automatic plc_pkg::q88_t pick_sample();
    int k;
    int lo;
    int hi;
    int t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return plc_pkg::q88_t'($urandom);
      4, 5, 6: begin
        k = $urandom_range(0, plc_pkg::PointsMax - 1);
        return plc_pkg::q88_t'(int'(curve_breaks[k]) + int'($urandom_range(0, 6)) - 3);
      end
      7: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: begin
        k  = $urandom_range(0, plc_pkg::PointsMax - 2);
        lo = curve_breaks[k];
        hi = curve_breaks[k+1];
        if (lo > hi) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
        return plc_pkg::q88_t'(lo + int'($urandom_range(0, hi - lo)));
      end
    endcase
  endfunction

  initial begin
    // reset curve: breakpoints and levels at 0, 1.0, 2.0, 3.0
    plc_pkg::q88_t corner_samples [];
    corner_samples = '{
      16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh0080,
      16'sh00ff, 16'sh0100, 16'sh0101, 16'sh0180, 16'sh01ff, 16'sh0200,
      16'sh0201, 16'sh02ff, 16'sh0300, 16'sh0301, 16'sh4000, 16'shc000,
      16'sh5555, 16'shaaaa
    };
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    sample_in_i = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = plc_pkg::REG_BREAK_0;
    cfg_data_i  = '0;
    fed         = 0;
    curves_run  = 1;
    burst_left  = $urandom_range(1, 24);
    for (int k = 0; k < plc_pkg::PointsMax; k++)
      curve_breaks[k] = plc_pkg::q88_t'(k * plc_pkg::ResetStep);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: range limits, breakpoints and their neighbors, at reset curve
    foreach (corner_samples[i]) feed(corner_samples[i]);

    // random samples under each table; every reload waits for a drained pipe
    for (int p = 0; p < RandomCurves; p++) begin
      settle();
      load_curve(p);
      curves_run++;
      for (int n = 0; n < BeatsPerCurve; n++) begin
        // occasional full drain in mid-stream
        if ($urandom_range(0, 149) == 0) settle();
        feed(pick_sample());
      end
    end

    settle();
    // catch any stray beat after the last expected one
    repeat (LatencyCycles + 5) @(negedge clk_i);

    $display("Mapped %0d samples through %0d curve tables, %0d results compared.",
             fed, curves_run, checked);
    $display("Tables covered full-scale, zero-width, unordered, flat and random breakpoints.");
    if (mismatches == 0 && backlog == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
